// ===== design/emt_pkg.sv =====
// Shared types and constants for the extent map translator.
// Depends on nothing; emt_ctrl, emt_dp and extent_map_translator import it.
package emt_pkg;

    localparam int DEFAULT_EXTENT_SLOTS = 8;
    localparam int BLOCK_W = 32;
    localparam int RUN_W   = 24;
    localparam int TOTAL_W = 27;
    localparam int SLOT_W  = 3;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [BLOCK_W-1:0] logical_block;
        logic [RUN_W-1:0]   run_length;
        logic [BLOCK_W-1:0] base_lba;
    } item_t;

    typedef struct packed {
        logic               status;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [BLOCK_W-1:0] block_addr;
        logic [RUN_W-1:0]   run_blocks;
        logic [TOTAL_W-1:0] total_blocks;
        logic               last;
    } result_t;

    typedef struct packed {
        logic capture;
        logic emit;
    } emt_cmd_t;

    typedef struct packed {
        logic out_free;
        logic more;
    } emt_sts_t;

endpackage

// ===== design/emt_stream_if.sv =====
// Valid/ready channel carrying one beat of a packed payload type.
// Depends on nothing; the payload type comes from emt_pkg at instantiation.
interface emt_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/emt_ctrl.sv =====
// Controller for the extent map translator: accepts an item, then issues
// emit commands until the datapath reports no more beats. Uses emt_pkg.
module emt_ctrl
    import emt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  emt_sts_t sts,
    output emt_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next  = state_reg;
        item_ready  = 1'b0;
        cmd.capture = 1'b0;
        cmd.emit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!sts.more)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/emt_dp.sv =====
// Datapath for the extent map translator: extent table lanes, captured item,
// slot picker, running total and the output register. Uses emt_pkg.
module emt_dp
    import emt_pkg::*;
#(
    parameter int EXTENT_SLOTS = DEFAULT_EXTENT_SLOTS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  emt_cmd_t cmd,
    input  item_t    item,
    output emt_sts_t sts,
    output logic     out_valid,
    output result_t  out_data,
    input  logic     out_ready
);

    localparam int N  = EXTENT_SLOTS;
    localparam int SW = (N > 1) ? $clog2(N) : 1;

    logic [BLOCK_W-1:0] start_reg [N];
    logic [BLOCK_W-1:0] base_reg  [N];
    logic [RUN_W-1:0]   len_reg   [N];

    logic [1:0]         mode_reg;
    logic [BLOCK_W-1:0] blk_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [BLOCK_W-1:0] lba_reg;
    logic [N-1:0]       match_reg;
    logic [N-1:0]       pend_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;

    logic [N-1:0]       occ;
    logic [N-1:0]       match_now;
    logic [N-1:0]       sel_vec;
    logic [N-1:0]       rest_vec;
    logic               pick_found;
    logic [SW-1:0]      pick_idx;
    logic [TOTAL_W-1:0] total_sum;
    result_t            rsp;
    logic               do_append;
    logic               do_wipe;

    // Each lane checks start <= block < start + length without wrap.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            occ[i]       = (len_reg[i] != '0);
            match_now[i] = occ[i]
                && (item.logical_block >= start_reg[i])
                && ({1'b0, item.logical_block} <
                    ({1'b0, start_reg[i]} + {{(BLOCK_W-RUN_W+1){1'b0}}, len_reg[i]}));
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_LOOKUP: sel_vec = match_reg;
            MODE_APPEND: sel_vec = ~occ;
            MODE_CLEAR:  sel_vec = pend_reg;
            default:     sel_vec = '0;
        endcase
    end

    always_comb
    begin
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (sel_vec[i])
            begin
                pick_found = 1'b1;
                pick_idx   = SW'(i);
            end
        end
    end

    assign rest_vec  = pend_reg & ~(N'(1) << pick_idx);
    assign total_sum = total_reg + TOTAL_W'(run_reg);

    always_comb
    begin
        rsp = '0;
        rsp.total_blocks = total_reg;
        rsp.last = 1'b1;
        case (mode_reg)
            MODE_LOOKUP:
            begin
                if (pick_found)
                begin
                    rsp.hit        = 1'b1;
                    rsp.slot       = SLOT_W'(pick_idx);
                    rsp.block_addr = base_reg[pick_idx] + (blk_reg - start_reg[pick_idx]);
                    rsp.run_blocks = len_reg[pick_idx];
                end
            end
            MODE_APPEND:
            begin
                if (pick_found)
                begin
                    rsp.status       = STATUS_OK;
                    rsp.slot         = SLOT_W'(pick_idx);
                    rsp.total_blocks = total_sum;
                end
                else
                begin
                    rsp.status = STATUS_FULL;
                end
            end
            MODE_CLEAR:
            begin
                rsp.total_blocks = '0;
                if (pick_found)
                begin
                    rsp.hit        = 1'b1;
                    rsp.slot       = SLOT_W'(pick_idx);
                    rsp.block_addr = base_reg[pick_idx];
                    rsp.run_blocks = len_reg[pick_idx];
                    rsp.last       = (rest_vec == '0);
                end
            end
            default:
            begin
                rsp.last = 1'b1;
            end
        endcase
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.more     = (mode_reg == MODE_CLEAR) && pick_found && (rest_vec != '0);

    assign do_append = cmd.emit && (mode_reg == MODE_APPEND) && pick_found;
    assign do_wipe   = cmd.emit && (mode_reg == MODE_CLEAR) && !sts.more;

    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            start_reg[pick_idx] <= blk_reg;
            base_reg[pick_idx]  <= lba_reg;
        end
        if (cmd.capture)
        begin
            mode_reg  <= item.mode;
            blk_reg   <= item.logical_block;
            run_reg   <= item.run_length;
            lba_reg   <= item.base_lba;
            match_reg <= match_now;
        end
        if (cmd.emit)
        begin
            out_data_reg <= rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                len_reg[i] <= '0;
            end
            pend_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_wipe)
            begin
                for (int i = 0; i < N; i++)
                begin
                    len_reg[i] <= '0;
                end
                total_reg <= '0;
            end
            else if (do_append)
            begin
                len_reg[pick_idx] <= run_reg;
                total_reg         <= total_sum;
            end
            if (cmd.capture)
            begin
                pend_reg <= occ;
            end
            else if (cmd.emit && (mode_reg == MODE_CLEAR))
            begin
                pend_reg <= rest_vec;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/extent_map_translator.sv =====
// Extent map translator: a small table of file extents with lookup,
// append and clear. The usage notes follow below.
// Depends on emt_pkg, emt_stream_if, emt_ctrl and emt_dp.
//
// Items enter on item_ch and results leave on result_ch, both valid/ready
// channels; a beat moves when valid and ready are high at a clock edge.
// Lookup and append give one result beat each; clear gives one beat per
// occupied slot in slot order (one beat with no hit if the table is empty)
// and then empties the table. The final beat of an item has last set.
// An item is taken in the idle state of the two-state controller, and its
// first result beat is registered in the response state once the output
// register is free. Slot compares run in parallel lanes when the item is
// taken, and the slot picker and the address adder fill the output
// register one beat per cycle while the receiver keeps up.
// If the receiver stalls, the held beat stays in the output register and
// the controller waits; item_ch drops ready until the item is finished.
// Reset marks every slot free, zeroes the block total and empties the
// output register; start and base entries are only read once written.
module extent_map_translator
    import emt_pkg::*;
#(
    parameter int EXTENT_SLOTS = DEFAULT_EXTENT_SLOTS
)
(
    input logic          clk,
    input logic          rst_n,
    emt_stream_if.sink   item_ch,
    emt_stream_if.source result_ch
);

    emt_cmd_t cmd;
    emt_sts_t sts;
    logic     item_ready;
    logic     res_valid;
    result_t  res_data;

    emt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_ch.valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    emt_dp #(
        .EXTENT_SLOTS (EXTENT_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item_ch.data),
        .sts       (sts),
        .out_valid (res_valid),
        .out_data  (res_data),
        .out_ready (result_ch.ready)
    );

    assign item_ch.ready   = item_ready;
    assign result_ch.valid = res_valid;
    assign result_ch.data  = res_data;

endmodule
